// File: sv/dtd_pkg.sv
// dtd_pkg: shared types, constants and calendar helpers for the date/time difference block
// used by dtd_stamp_conv and datetime_difference; no other dependencies
`timescale 1ns / 1ps

package dtd_pkg;

	// field widths
	localparam int DAY_W    = 5;
	localparam int MONTH_W  = 4;
	localparam int YEAR_W   = 14;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int SECOND_W = 6;
	localparam int DNUM_W   = 22;
	localparam int DOY_W    = 9;

	// calendar limits
	localparam logic [YEAR_W-1:0]   YEAR_MAX   = YEAR_W'(9999);
	localparam logic [MONTH_W-1:0]  MONTH_FEB  = MONTH_W'(2);
	localparam logic [MONTH_W-1:0]  MONTH_MAR  = MONTH_W'(3);
	localparam logic [MONTH_W-1:0]  MONTH_DEC  = MONTH_W'(12);
	localparam logic [HOUR_W-1:0]   HOUR_MAX   = HOUR_W'(23);
	localparam logic [MINUTE_W-1:0] MINUTE_MAX = MINUTE_W'(59);
	localparam logic [SECOND_W-1:0] SECOND_MAX = SECOND_W'(59);
	localparam logic [HOUR_W-1:0]   HOURS_PER_DAY = HOUR_W'(24);
	localparam logic [MINUTE_W-1:0] MINS_PER_HOUR = MINUTE_W'(60);
	localparam logic [SECOND_W-1:0] SECS_PER_MIN  = SECOND_W'(60);

	// year / 100 as multiply by reciprocal, exact for all 14-bit years
	localparam int RECIP_100   = 5243;
	localparam int RECIP_W     = 13;
	localparam int RECIP_SHIFT = 19;
	localparam int CENT_W      = 8;
	localparam int YEAR_OFFSET = 400;

	// one timestamp as it arrives
	typedef struct packed {
		logic [DAY_W-1:0]    day;
		logic [MONTH_W-1:0]  month;
		logic [YEAR_W-1:0]   year;
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic [SECOND_W-1:0] second;
	} dtd_stamp_t;

	// timestamp as day count plus time of day, with its check result
	typedef struct packed {
		logic                ok;
		logic [DNUM_W-1:0]   dnum;
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic [SECOND_W-1:0] second;
	} dtd_time_t;

	// days before the start of a month in a march-based year
	function automatic logic [DOY_W-1:0] doy_offset(input logic [MONTH_W-1:0] mp);
		logic [DOY_W-1:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

// File: sv/dtd_stamp_conv.sv
// dtd_stamp_conv: checks one timestamp and turns its date into a day count
// depends on dtd_pkg
`timescale 1ns / 1ps

module dtd_stamp_conv (
	input  dtd_pkg::dtd_stamp_t stamp,
	output dtd_pkg::dtd_time_t  tod
);
	import dtd_pkg::*;

	localparam int PROD_W = YEAR_W + RECIP_W;
	localparam int YY_W   = YEAR_W + 1;
	localparam int SUM_W  = DNUM_W + 2;

	logic [PROD_W-1:0]  cent_prod;
	logic [CENT_W-1:0]  cent;
	logic [YY_W-1:0]    cent_x100;
	logic               cent_exact;
	logic               leap;
	logic               early;
	logic [YY_W-1:0]    yy;
	logic [CENT_W:0]    yy_cent;
	logic [MONTH_W-1:0] mp;
	logic [DAY_W-1:0]   mlen;
	logic [SUM_W-1:0]   dsum;

	// century of the year and whether the year is a whole century
	assign cent_prod  = PROD_W'(stamp.year) * PROD_W'(RECIP_100);
	assign cent       = cent_prod[RECIP_SHIFT +: CENT_W];
	assign cent_x100  = (YY_W'(cent) << 6) + (YY_W'(cent) << 5) + (YY_W'(cent) << 2);
	assign cent_exact = (cent_x100 == YY_W'(stamp.year));
	assign leap       = (stamp.year[1:0] == 2'b00) && (!cent_exact || (cent[1:0] == 2'b00));

	// month length with leap years
	always_comb begin
		case (stamp.month) inside
			MONTH_FEB:                mlen = leap ? DAY_W'(29) : DAY_W'(28);
			4'd4, 4'd6, 4'd9, 4'd11:  mlen = DAY_W'(30);
			default:                  mlen = DAY_W'(31);
		endcase
	end

	// march-based year, shifted forward 400 years to stay positive
	assign early   = (stamp.month <= MONTH_FEB);
	assign yy      = YY_W'(stamp.year) + YY_W'(YEAR_OFFSET) - YY_W'(early);
	assign yy_cent = (CENT_W+1)'(cent) + (CENT_W+1)'(YEAR_OFFSET / 100)
	               - (CENT_W+1)'(early && cent_exact);
	assign mp      = early ? (stamp.month + MONTH_W'(9)) : (stamp.month - MONTH_MAR);

	// day count: 365 per year plus leap days plus day of year
	assign dsum = (SUM_W'(yy) << 8) + (SUM_W'(yy) << 6) + (SUM_W'(yy) << 5)
	            + (SUM_W'(yy) << 3) + (SUM_W'(yy) << 2) + SUM_W'(yy)
	            + SUM_W'(yy >> 2) - SUM_W'(yy_cent) + SUM_W'(yy_cent >> 2)
	            + SUM_W'(doy_offset(mp)) + SUM_W'(stamp.day);

	// range checks and packing
	always_comb begin
		tod.ok = (stamp.month >= MONTH_W'(1)) && (stamp.month <= MONTH_DEC)
		      && (stamp.year <= YEAR_MAX)
		      && (stamp.day >= DAY_W'(1)) && (stamp.day <= mlen)
		      && (stamp.hour <= HOUR_MAX)
		      && (stamp.minute <= MINUTE_MAX)
		      && (stamp.second <= SECOND_MAX);
		tod.dnum   = dsum[DNUM_W-1:0];
		tod.hour   = stamp.hour;
		tod.minute = stamp.minute;
		tod.second = stamp.second;
	end

endmodule

// File: sv/datetime_difference.sv
// datetime_difference: absolute difference of two checked calendar timestamps
// depends on dtd_pkg and dtd_stamp_conv
//
//  channel | signals                          | role
//  --------+----------------------------------+------------------------------
//  in      | in_valid, in_ready, *_a, *_b     | one word: two timestamps
//  out     | out_valid, out_ready, valid_res, | one word: check flag and
//          | diff_days/hours/minutes/seconds  | days + h:m:s difference
//
// three register stages (input, day count, output); one word accepted
// every cycle while the output side keeps up
// each stage holds its word when the next stage is full and stalled, so
// in_ready only drops once all three stages are occupied
// arst_n clears the stage valid flags; payload registers are not reset
`timescale 1ns / 1ps

module datetime_difference (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [dtd_pkg::DAY_W-1:0]     day_a,
	input  logic [dtd_pkg::MONTH_W-1:0]   month_a,
	input  logic [dtd_pkg::YEAR_W-1:0]    year_a,
	input  logic [dtd_pkg::HOUR_W-1:0]    hour_a,
	input  logic [dtd_pkg::MINUTE_W-1:0]  minute_a,
	input  logic [dtd_pkg::SECOND_W-1:0]  second_a,
	input  logic [dtd_pkg::DAY_W-1:0]     day_b,
	input  logic [dtd_pkg::MONTH_W-1:0]   month_b,
	input  logic [dtd_pkg::YEAR_W-1:0]    year_b,
	input  logic [dtd_pkg::HOUR_W-1:0]    hour_b,
	input  logic [dtd_pkg::MINUTE_W-1:0]  minute_b,
	input  logic [dtd_pkg::SECOND_W-1:0]  second_b,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          valid_res,
	output logic [dtd_pkg::DNUM_W-1:0]    diff_days,
	output logic [dtd_pkg::HOUR_W-1:0]    diff_hours,
	output logic [dtd_pkg::MINUTE_W-1:0]  diff_minutes,
	output logic [dtd_pkg::SECOND_W-1:0]  diff_seconds
);
	import dtd_pkg::*;

	logic       valid_s1, valid_s2, valid_s3;
	logic       adv_s2, adv_s3;
	dtd_stamp_t a_s1, b_s1;
	dtd_time_t  ta_c, tb_c;
	dtd_time_t  ta_s2, tb_s2;
	dtd_time_t  big, sml;
	logic       a_ge;

	logic [SECOND_W:0]   sec_raw;
	logic [MINUTE_W:0]   min_raw;
	logic [HOUR_W:0]     hour_raw;
	logic                sec_brw, min_brw, hour_brw;
	logic [SECOND_W-1:0] sec_d;
	logic [MINUTE_W-1:0] min_d;
	logic [HOUR_W-1:0]   hour_d;
	logic [DNUM_W-1:0]   day_d;
	logic                ok_c;

	logic                valid_res_s3;
	logic [DNUM_W-1:0]   days_s3;
	logic [HOUR_W-1:0]   hours_s3;
	logic [MINUTE_W-1:0] minutes_s3;
	logic [SECOND_W-1:0] seconds_s3;

	// stage handshake: a stage loads when it is empty or its word moves on
	assign adv_s3   = !valid_s3 || out_ready;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign in_ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (adv_s2)   valid_s2 <= valid_s1;
			if (adv_s3)   valid_s3 <= valid_s2;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			a_s1 <= '{day: day_a, month: month_a, year: year_a,
			          hour: hour_a, minute: minute_a, second: second_a};
			b_s1 <= '{day: day_b, month: month_b, year: year_b,
			          hour: hour_b, minute: minute_b, second: second_b};
		end
	end

	// date check and day count for each timestamp
	dtd_stamp_conv u_conv_a (.stamp(a_s1), .tod(ta_c));
	dtd_stamp_conv u_conv_b (.stamp(b_s1), .tod(tb_c));

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s2) begin
			ta_s2 <= ta_c;
			tb_s2 <= tb_c;
		end
	end

	// order the two stamps, larger first
	assign a_ge = {ta_s2.dnum, ta_s2.hour, ta_s2.minute, ta_s2.second}
	           >= {tb_s2.dnum, tb_s2.hour, tb_s2.minute, tb_s2.second};
	assign big  = a_ge ? ta_s2 : tb_s2;
	assign sml  = a_ge ? tb_s2 : ta_s2;

	// mixed-radix subtract: seconds, minutes, hours, days with borrows
	always_comb begin
		sec_raw  = {1'b0, big.second} - {1'b0, sml.second};
		sec_brw  = sec_raw[SECOND_W];
		sec_d    = sec_brw ? (sec_raw[SECOND_W-1:0] + SECS_PER_MIN) : sec_raw[SECOND_W-1:0];
		min_raw  = {1'b0, big.minute} - {1'b0, sml.minute} - (MINUTE_W+1)'(sec_brw);
		min_brw  = min_raw[MINUTE_W];
		min_d    = min_brw ? (min_raw[MINUTE_W-1:0] + MINS_PER_HOUR) : min_raw[MINUTE_W-1:0];
		hour_raw = {1'b0, big.hour} - {1'b0, sml.hour} - (HOUR_W+1)'(min_brw);
		hour_brw = hour_raw[HOUR_W];
		hour_d   = hour_brw ? (hour_raw[HOUR_W-1:0] + HOURS_PER_DAY) : hour_raw[HOUR_W-1:0];
		day_d    = big.dnum - sml.dnum - DNUM_W'(hour_brw);
		ok_c     = ta_s2.ok && tb_s2.ok;
	end

	// output register, zeroed when either stamp fails its check
	always_ff @(posedge clk) begin
		if (valid_s2 && adv_s3) begin
			valid_res_s3 <= ok_c;
			days_s3      <= ok_c ? day_d  : '0;
			hours_s3     <= ok_c ? hour_d : '0;
			minutes_s3   <= ok_c ? min_d  : '0;
			seconds_s3   <= ok_c ? sec_d  : '0;
		end
	end

	assign out_valid    = valid_s3;
	assign valid_res    = valid_res_s3;
	assign diff_days    = days_s3;
	assign diff_hours   = hours_s3;
	assign diff_minutes = minutes_s3;
	assign diff_seconds = seconds_s3;

endmodule

// File: dv/datetime_difference_test.sv
// datetime_difference_test: self-checking bench for the date/time difference block
// directed table of calendar corner cases, then random timestamp pairs with idle and stall bursts
// depends on dtd_pkg and datetime_difference
`timescale 1ns / 1ps

module datetime_difference_test;
	import dtd_pkg::*;

	// expected difference word, same field order as the output ports
	typedef struct packed {
		logic              ok;
		logic [DNUM_W-1:0] days;
		logic [HOUR_W-1:0] hours;
		logic [MINUTE_W-1:0] minutes;
		logic [SECOND_W-1:0] seconds;
	} diff_result_t;

	// one directed row; the typed expectation is used only when fixed is set
	typedef struct packed {
		dtd_stamp_t   a;
		dtd_stamp_t   b;
		logic         fixed;
		diff_result_t want;
	} stim_row_t;

	localparam diff_result_t NO_RESULT   = '0;
	localparam diff_result_t ZERO_DIFF   = {1'b1, 22'd0, 5'd0, 6'd0, 6'd0};
	localparam diff_result_t ONE_SECOND  = {1'b1, 22'd0, 5'd0, 6'd0, 6'd1};
	localparam diff_result_t WIDEST_SPAN = {1'b1, 22'd3652424, 5'd23, 6'd59, 6'd59};

	localparam int RANDOM_ITEMS   = 1225;
	localparam int PRESSURE_AT    = 300;
	localparam int PRESSURE_ITEMS = 20;
	localparam int HOLD_CYCLES    = 60;
	localparam int CALM_TAIL      = 150;
	localparam int DRAIN_CYCLES   = 8;
	localparam int QUIET_LIMIT    = 1000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [DAY_W-1:0]    day_a = '0;
	logic [MONTH_W-1:0]  month_a = '0;
	logic [YEAR_W-1:0]   year_a = '0;
	logic [HOUR_W-1:0]   hour_a = '0;
	logic [MINUTE_W-1:0] minute_a = '0;
	logic [SECOND_W-1:0] second_a = '0;
	logic [DAY_W-1:0]    day_b = '0;
	logic [MONTH_W-1:0]  month_b = '0;
	logic [YEAR_W-1:0]   year_b = '0;
	logic [HOUR_W-1:0]   hour_b = '0;
	logic [MINUTE_W-1:0] minute_b = '0;
	logic [SECOND_W-1:0] second_b = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic                valid_res;
	logic [DNUM_W-1:0]   diff_days;
	logic [HOUR_W-1:0]   diff_hours;
	logic [MINUTE_W-1:0] diff_minutes;
	logic [SECOND_W-1:0] diff_seconds;

	diff_result_t pending_diffs[$];
	int unsigned  mismatches = 0;
	int unsigned  quiet_cycles = 0;
	int unsigned  hold_req = 0;
	bit           tx_idle = 1'b1;
	bit           rx_idle = 1'b1;
	int unsigned  year_edges[8] = '{0, 1, 4, 100, 400, 1900, 2000, 9999};

	datetime_difference dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.day_a        (day_a),
		.month_a      (month_a),
		.year_a       (year_a),
		.hour_a       (hour_a),
		.minute_a     (minute_a),
		.second_a     (second_a),
		.day_b        (day_b),
		.month_b      (month_b),
		.year_b       (year_b),
		.hour_b       (hour_b),
		.minute_b     (minute_b),
		.second_b     (second_b),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.valid_res    (valid_res),
		.diff_days    (diff_days),
		.diff_hours   (diff_hours),
		.diff_minutes (diff_minutes),
		.diff_seconds (diff_seconds)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// gregorian leap rule, year 0 included
	function automatic bit is_leap(int unsigned y);
		return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
	endfunction

	function automatic int unsigned month_days(int unsigned m, int unsigned y);
		if (m == 2)
			return is_leap(y) ? 29 : 28;
		if (m == 4 || m == 6 || m == 9 || m == 11)
			return 30;
		return 31;
	endfunction

	function automatic bit stamp_valid(dtd_stamp_t s);
		if (s.month < 1 || s.month > 12 || s.year > 9999)
			return 1'b0;
		if (s.day < 1 || s.day > month_days(s.month, s.year))
			return 1'b0;
		return s.hour <= 23 && s.minute <= 59 && s.second <= 59;
	endfunction

	// seconds since an epoch 400 years before year 0, years starting in march
	function automatic longint unsigned stamp_seconds(dtd_stamp_t s);
		int unsigned yy, era, yoe, mp, doy, doe;
		longint unsigned dnum;
		yy   = int'(s.year) + 400 - ((s.month <= 2) ? 1 : 0);
		era  = yy / 400;
		yoe  = yy - era * 400;
		mp   = (int'(s.month) + 9) % 12;
		doy  = (153 * mp + 2) / 5 + int'(s.day) - 1;
		doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
		dnum = longint'(era) * 146097 + doe;
		return dnum * 86400 + longint'(s.hour) * 3600 + longint'(s.minute) * 60 + s.second;
	endfunction

	// absolute difference of two stamps, all zero when either is malformed
	function automatic diff_result_t calc_difference(dtd_stamp_t a, dtd_stamp_t b);
		diff_result_t r;
		longint unsigned ta, tb, span, rem;
		r = NO_RESULT;
		if (!stamp_valid(a) || !stamp_valid(b))
			return r;
		ta   = stamp_seconds(a);
		tb   = stamp_seconds(b);
		span = (ta >= tb) ? ta - tb : tb - ta;
		rem  = span % 86400;
		r.ok      = 1'b1;
		r.days    = DNUM_W'(span / 86400);
		r.hours   = HOUR_W'(rem / 3600);
		r.minutes = MINUTE_W'((rem % 3600) / 60);
		r.seconds = SECOND_W'(rem % 60);
		return r;
	endfunction

	function automatic dtd_stamp_t stamp(int unsigned d, int unsigned mo, int unsigned y,
			int unsigned h, int unsigned mi, int unsigned s);
		dtd_stamp_t t;
		t.day    = DAY_W'(d);
		t.month  = MONTH_W'(mo);
		t.year   = YEAR_W'(y);
		t.hour   = HOUR_W'(h);
		t.minute = MINUTE_W'(mi);
		t.second = SECOND_W'(s);
		return t;
	endfunction

	function automatic stim_row_t row(dtd_stamp_t a, dtd_stamp_t b, logic fixed,
			diff_result_t want);
		stim_row_t r;
		r.a     = a;
		r.b     = b;
		r.fixed = fixed;
		r.want  = want;
		return r;
	endfunction

	// well-formed stamp, leaning on century years, month ends and end of day
	function automatic dtd_stamp_t pick_stamp();
		dtd_stamp_t s;
		int unsigned len;
		if ($urandom_range(0, 7) == 0)
			s.year = YEAR_W'(year_edges[$urandom_range(0, 7)]);
		else
			s.year = YEAR_W'($urandom_range(0, 9999));
		s.month  = MONTH_W'($urandom_range(1, 12));
		len      = month_days(s.month, s.year);
		s.day    = DAY_W'(($urandom_range(0, 3) == 0) ? len : $urandom_range(1, len));
		s.hour   = HOUR_W'(($urandom_range(0, 7) == 0) ? 23 : $urandom_range(0, 23));
		s.minute = MINUTE_W'(($urandom_range(0, 7) == 0) ? 59 : $urandom_range(0, 59));
		s.second = SECOND_W'(($urandom_range(0, 7) == 0) ? 59 : $urandom_range(0, 59));
		return s;
	endfunction

	// mostly legal pairs, some close together, some with one bad field, some raw bits
	function automatic void random_pair(output dtd_stamp_t a, output dtd_stamp_t b);
		int unsigned kind, len;
		bit          on_a;
		dtd_stamp_t  s;
		kind = $urandom_range(0, 99);
		a = pick_stamp();
		b = pick_stamp();
		if (kind < 10) begin
			a = dtd_stamp_t'({$urandom, $urandom});
			b = dtd_stamp_t'({$urandom, $urandom});
		end else if (kind < 20) begin
			// same day, other time
			b = a;
			b.hour   = HOUR_W'($urandom_range(0, 23));
			b.minute = MINUTE_W'($urandom_range(0, 59));
			b.second = SECOND_W'($urandom_range(0, 59));
		end else if (kind < 28) begin
			// same month, other day
			b = a;
			b.day = DAY_W'($urandom_range(1, month_days(a.month, a.year)));
		end else if (kind < 42) begin
			// one field pushed out of its legal range
			on_a = 1'($urandom_range(0, 1));
			s = on_a ? a : b;
			case ($urandom_range(0, 5))
				0: begin
					len = month_days(s.month, s.year);
					s.day = (len == 31 || $urandom_range(0, 1) == 0) ?
						'0 : DAY_W'($urandom_range(len + 1, 31));
				end
				1: s.month = ($urandom_range(0, 1) == 0) ? '0 : MONTH_W'($urandom_range(13, 15));
				2: s.year = YEAR_W'($urandom_range(10000, 16383));
				3: s.hour = HOUR_W'($urandom_range(24, 31));
				4: s.minute = MINUTE_W'($urandom_range(60, 63));
				default: s.second = SECOND_W'($urandom_range(60, 63));
			endcase
			if (on_a)
				a = s;
			else
				b = s;
		end
	endfunction

	// offer one word, wait for it to be taken, then queue its expected difference
	task automatic send_word(dtd_stamp_t a, dtd_stamp_t b, logic fixed, diff_result_t want);
		if (tx_idle && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		day_a    <= a.day;
		month_a  <= a.month;
		year_a   <= a.year;
		hour_a   <= a.hour;
		minute_a <= a.minute;
		second_a <= a.second;
		day_b    <= b.day;
		month_b  <= b.month;
		year_b   <= b.year;
		hour_b   <= b.hour;
		minute_b <= b.minute;
		second_b <= b.second;
		do
			@(posedge clk);
		while (!in_ready);
		pending_diffs.push_back(fixed ? want : calc_difference(a, b));
	endtask

	// drop valid and wait until every queued difference has come out
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_diffs.size() != 0);
	endtask

	task automatic compare_field(string what, longint unsigned want, longint unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	// receiver: check each taken word, random stall bursts, long hold on request
	initial begin : sink
		int unsigned stall_left;
		diff_result_t want;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (pending_diffs.size() == 0) begin
					mismatches++;
					$display("%0t: result word with nothing expected, got valid_res %0d days %0d",
						$time, valid_res, diff_days);
				end else begin
					want = pending_diffs.pop_front();
					compare_field("valid_res", want.ok, valid_res);
					compare_field("diff_days", want.days, diff_days);
					compare_field("diff_hours", want.hours, diff_hours);
					compare_field("diff_minutes", want.minutes, diff_minutes);
					compare_field("diff_seconds", want.seconds, diff_seconds);
				end
			end
			if (hold_req != 0) begin
				stall_left = hold_req;
				hold_req = 0;
			end else if (stall_left == 0 && rx_idle && $urandom_range(0, 3) == 0) begin
				stall_left = $urandom_range(1, 12);
			end
			if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles where neither channel moves a word
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// stimulus sequence
	initial begin : source
		stim_row_t  plan[$];
		dtd_stamp_t a, b;
		bit [1:0]   mode;

		// equal stamps, widest span both ways, year rollover by one second
		plan.push_back(row(stamp(29, 2, 2024, 12, 30, 45), stamp(29, 2, 2024, 12, 30, 45),
			1'b1, ZERO_DIFF));
		plan.push_back(row(stamp(1, 1, 0, 0, 0, 0), stamp(31, 12, 9999, 23, 59, 59),
			1'b1, WIDEST_SPAN));
		plan.push_back(row(stamp(31, 12, 9999, 23, 59, 59), stamp(1, 1, 0, 0, 0, 0),
			1'b1, WIDEST_SPAN));
		plan.push_back(row(stamp(31, 12, 1999, 23, 59, 59), stamp(1, 1, 2000, 0, 0, 0),
			1'b1, ONE_SECOND));
		// july 31 is legal, leap day in year 0 and 2000, end-of-day wrap
		plan.push_back(row(stamp(31, 7, 2021, 8, 0, 0), stamp(1, 8, 2021, 7, 0, 0),
			1'b0, NO_RESULT));
		plan.push_back(row(stamp(29, 2, 0, 0, 0, 0), stamp(1, 3, 0, 0, 0, 0), 1'b0, NO_RESULT));
		plan.push_back(row(stamp(29, 2, 2000, 6, 6, 6), stamp(28, 2, 1900, 18, 18, 18),
			1'b0, NO_RESULT));
		plan.push_back(row(stamp(15, 6, 1500, 23, 59, 59), stamp(15, 6, 1500, 0, 0, 0),
			1'b0, NO_RESULT));
		plan.push_back(row(stamp(31, 12, 9999, 0, 0, 1), stamp(31, 12, 9998, 23, 59, 59),
			1'b0, NO_RESULT));
		// malformed stamps on either side
		plan.push_back(row(stamp(29, 2, 1900, 0, 0, 0), stamp(1, 1, 2000, 0, 0, 0),
			1'b1, NO_RESULT));
		plan.push_back(row(stamp(30, 2, 2000, 0, 0, 0), stamp(1, 1, 2000, 0, 0, 0),
			1'b1, NO_RESULT));
		plan.push_back(row(stamp(31, 4, 2023, 0, 0, 0), stamp(1, 1, 2000, 0, 0, 0),
			1'b1, NO_RESULT));
		plan.push_back(row(stamp(0, 5, 2023, 0, 0, 0), stamp(1, 1, 2000, 0, 0, 0),
			1'b1, NO_RESULT));
		plan.push_back(row(stamp(1, 0, 2023, 0, 0, 0), stamp(1, 1, 2000, 0, 0, 0),
			1'b1, NO_RESULT));
		plan.push_back(row(stamp(1, 13, 2023, 0, 0, 0), stamp(1, 1, 2000, 0, 0, 0),
			1'b1, NO_RESULT));
		plan.push_back(row(stamp(31, 15, 16383, 31, 63, 63), stamp(1, 1, 2000, 0, 0, 0),
			1'b1, NO_RESULT));
		plan.push_back(row(stamp(1, 1, 10000, 0, 0, 0), stamp(1, 1, 2000, 0, 0, 0),
			1'b1, NO_RESULT));
		plan.push_back(row(stamp(1, 1, 2000, 24, 0, 0), stamp(1, 1, 2000, 0, 0, 0),
			1'b1, NO_RESULT));
		plan.push_back(row(stamp(1, 1, 2000, 0, 60, 0), stamp(1, 1, 2000, 0, 0, 0),
			1'b1, NO_RESULT));
		plan.push_back(row(stamp(1, 1, 2000, 0, 0, 60), stamp(1, 1, 2000, 0, 0, 0),
			1'b1, NO_RESULT));
		plan.push_back(row(stamp(1, 1, 2000, 0, 0, 0), stamp(1, 1, 0, 31, 63, 63),
			1'b1, NO_RESULT));
		plan.push_back(row(stamp(1, 1, 2000, 0, 0, 0), stamp(1, 0, 2000, 0, 0, 0),
			1'b1, NO_RESULT));
		plan.push_back(row(stamp(0, 0, 0, 0, 0, 0), stamp(0, 0, 0, 0, 0, 0), 1'b1, NO_RESULT));

		// reset
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (plan[k])
			send_word(plan[k].a, plan[k].b, plan[k].fixed, plan[k].want);

		// random pairs, idling mode changes every hundred words, calm at the end
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 100 == 0) begin
				mode = 2'($urandom_range(0, 3));
				tx_idle = mode[0];
				rx_idle = mode[1];
			end
			if (i >= RANDOM_ITEMS - CALM_TAIL) begin
				tx_idle = 1'b0;
				rx_idle = 1'b0;
			end
			if (i == PRESSURE_AT) begin
				// long receiver hold while words keep coming, then a full drain
				tx_idle = 1'b0;
				hold_req = HOLD_CYCLES;
				for (int j = 0; j < PRESSURE_ITEMS; j++) begin
					random_pair(a, b);
					send_word(a, b, 1'b0, NO_RESULT);
				end
				drain();
			end
			random_pair(a, b);
			send_word(a, b, 1'b0, NO_RESULT);
		end

		// wait out the pipeline and look for stray words
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
